@@ rtl/bpd_pkg.sv @@
`timescale 1ns / 1ps
// package for block_partition_destination: widths, register and status codes,
// the pipeline word layout and one restoring-division step. no dependencies.
package bpd_pkg;

   localparam int POSITION_BITS = 32;
   localparam int PART_BITS     = 16;
   localparam int OFFSET_BITS   = 32;
   localparam int STATUS_BITS   = 2;

   // csr layout: 32-bit registers at a 4-byte stride, 64-bit ones at 8
   localparam int DATA_BITS   = (POSITION_BITS > 32) ? 64 : 32;
   localparam int STRIDE_BITS = (POSITION_BITS > 32) ? 3 : 2;
   localparam int INDEX_BITS  = 2;
   localparam int ADDR_BITS   = STRIDE_BITS + INDEX_BITS;

   // width of start_position + element_offset with its carry
   localparam int SUM_BITS = ((POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS) + 1;

   // iteration counter of the setup divider
   localparam int CNT_BITS = $clog2(POSITION_BITS);

   typedef logic [INDEX_BITS-1:0] reg_index_type;
   localparam reg_index_type REG_NUM_PARTS      = 2'd0;
   localparam reg_index_type REG_TOTAL_ELEMENTS = 2'd1;
   localparam reg_index_type REG_START_POSITION = 2'd2;
   localparam reg_index_type REG_LOCAL_COUNT    = 2'd3;

   typedef logic [STATUS_BITS-1:0] status_type;
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_OFFSET = 2'd1;
   localparam status_type ST_RANGE  = 2'd2;

   // one word in flight through the divide stages
   typedef struct packed {
      status_type               status;
      logic [POSITION_BITS-1:0] rem;
      logic [PART_BITS-1:0]     dvd_lo;
      logic [POSITION_BITS-1:0] divisor;
      logic [PART_BITS-1:0]     addend;
      logic [PART_BITS-1:0]     quo;
   } item_type;

   // one quotient bit: bring in the next dividend bit, trial subtract
   function automatic item_type div_step(input item_type cur);
      item_type               nxt;
      logic [POSITION_BITS:0] trial;
      logic                   qbit;
      nxt    = cur;
      trial  = {cur.rem, cur.dvd_lo[PART_BITS-1]};
      qbit   = (trial >= {1'b0, cur.divisor});
      nxt.rem = qbit ? (trial[POSITION_BITS-1:0] - cur.divisor) : trial[POSITION_BITS-1:0];
      nxt.dvd_lo = cur.dvd_lo << 1;
      nxt.quo    = (cur.quo << 1) | PART_BITS'(qbit);
      return nxt;
   endfunction

endpackage

@@ rtl/block_partition_destination.sv @@
`timescale 1ns / 1ps
// block_partition_destination: owner part of each local element under a
// balanced block distribution. a word passes PART_BITS+3 = 19 register stages
// from the accepting edge to rsp_valid; one word per cycle while rsp_ready does
// not stall the pipeline, set by the one-bit-per-stage divide pipeline.
// a write to num_parts or total_elements starts or restarts a setup division
// during which no word is taken.
// synchronous active-high reset loads the register reset values and empties
// the pipeline.
module block_partition_destination
   import bpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input words
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OFFSET_BITS-1:0] req_element_offset,
   // result words
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PART_BITS-1:0]   rsp_owner_part,
   output logic [STATUS_BITS-1:0] rsp_status,
   // csr port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_BITS-1:0]   paddr,
   input  logic [DATA_BITS-1:0]   pwdata,
   output logic [DATA_BITS-1:0]   prdata,
   output logic                   pready
);

   typedef enum logic [3:0] {
      SQ_IDLE   = 4'b0001,
      SQ_LOAD   = 4'b0010,
      SQ_DIVIDE = 4'b0100,
      SQ_SCALE  = 4'b1000
   } seq_type;

   // csr registers
   logic [PART_BITS-1:0]     num_parts_ff;
   logic [POSITION_BITS-1:0] total_ff;
   logic [POSITION_BITS-1:0] start_ff;
   logic [POSITION_BITS-1:0] local_count_ff;

   // setup sequencer and derived distribution values
   seq_type                  seq_ff, seq_in;
   logic [CNT_BITS-1:0]      cd_cnt_ff;
   logic [PART_BITS-1:0]     cd_rem_ff;
   logic [POSITION_BITS-1:0] cd_quo_ff;
   logic [POSITION_BITS-1:0] div_lo_ff;    // base block size
   logic [POSITION_BITS-1:0] div_hi_ff;    // size of the larger blocks
   logic [POSITION_BITS-1:0] thresh_ff;    // first position of the base blocks
   logic [PART_BITS-1:0]     extra_ff;     // count of larger blocks

   logic [PART_BITS-1:0]     parts_eff;
   logic                     csr_wr;
   reg_index_type            csr_index;
   logic                     setup_start;
   logic [PART_BITS:0]       cd_trial;
   logic                     cd_qbit;
   logic [POSITION_BITS-1:0] q_plus;
   logic [PART_BITS+POSITION_BITS-1:0] scale_prod;

   // pipeline
   logic                     s1_valid_ff;
   logic [SUM_BITS-1:0]      s1_pos_ff;
   status_type               s1_status_ff;
   logic                     dv_valid_ff [0:PART_BITS];
   item_type                 dv_ff       [0:PART_BITS];
   logic                     dv_rdy      [0:PART_BITS];
   logic                     rsp_valid_ff;
   logic [PART_BITS-1:0]     rsp_owner_ff;
   status_type               rsp_status_ff;

   logic                     out_rdy;
   logic                     s1_rdy;
   logic                     pipe_busy;
   logic                     accept;
   logic [SUM_BITS-1:0]      pos_sum;
   status_type               entry_status;
   logic                     pos_lt;
   logic [POSITION_BITS-1:0] s1_pos_low;
   logic [POSITION_BITS-1:0] dividend;
   item_type                 load_item;
   item_type                 last_item;

   // csr decode
   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite;
   assign csr_index = paddr[ADDR_BITS-1:STRIDE_BITS];
   assign setup_start = csr_wr &
      ((csr_index == REG_NUM_PARTS) || (csr_index == REG_TOTAL_ELEMENTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff   <= PART_BITS'(1);
         total_ff       <= '0;
         start_ff       <= '0;
         local_count_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            REG_NUM_PARTS:      num_parts_ff   <= pwdata[PART_BITS-1:0];
            REG_TOTAL_ELEMENTS: total_ff       <= pwdata[POSITION_BITS-1:0];
            REG_START_POSITION: start_ff       <= pwdata[POSITION_BITS-1:0];
            REG_LOCAL_COUNT:    local_count_ff <= pwdata[POSITION_BITS-1:0];
            default: ;
         endcase
      end
   end

   // csr read mux
   always_comb begin
      case (csr_index)
         REG_NUM_PARTS:      prdata = DATA_BITS'(num_parts_ff);
         REG_TOTAL_ELEMENTS: prdata = DATA_BITS'(total_ff);
         REG_START_POSITION: prdata = DATA_BITS'(start_ff);
         REG_LOCAL_COUNT:    prdata = DATA_BITS'(local_count_ff);
         default:            prdata = '0;
      endcase
   end

   // setup divider: total / parts, one quotient bit a cycle
   assign parts_eff  = (num_parts_ff == '0) ? PART_BITS'(1) : num_parts_ff;
   assign cd_trial   = {cd_rem_ff, cd_quo_ff[POSITION_BITS-1]};
   assign cd_qbit    = (cd_trial >= {1'b0, parts_eff});
   assign q_plus     = cd_quo_ff + POSITION_BITS'(1);
   assign scale_prod = (PART_BITS+POSITION_BITS)'(cd_rem_ff) *
                       (PART_BITS+POSITION_BITS)'(q_plus);

   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SQ_IDLE:   seq_in = SQ_IDLE;
         SQ_LOAD:   seq_in = SQ_DIVIDE;
         SQ_DIVIDE: if (cd_cnt_ff == '0) seq_in = SQ_SCALE;
         SQ_SCALE:  seq_in = SQ_IDLE;
         default:   seq_in = SQ_IDLE;
      endcase
      // a new part count or total starts the division over
      if (setup_start) seq_in = SQ_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SQ_IDLE;
         div_lo_ff <= POSITION_BITS'(1);
         div_hi_ff <= POSITION_BITS'(1);
         thresh_ff <= '0;
         extra_ff  <= '0;
      end else begin
         seq_ff <= seq_in;
         if (seq_ff == SQ_SCALE) begin
            if (cd_quo_ff == '0) begin
               // fewer elements than parts: owner is the position itself
               div_lo_ff <= POSITION_BITS'(1);
               div_hi_ff <= POSITION_BITS'(1);
               thresh_ff <= '0;
               extra_ff  <= '0;
            end else begin
               div_lo_ff <= cd_quo_ff;
               div_hi_ff <= q_plus;
               thresh_ff <= scale_prod[POSITION_BITS-1:0];
               extra_ff  <= cd_rem_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (seq_ff)
         SQ_LOAD: begin
            cd_cnt_ff <= CNT_BITS'(POSITION_BITS - 1);
            cd_rem_ff <= '0;
            cd_quo_ff <= total_ff;
         end
         SQ_DIVIDE: begin
            cd_cnt_ff <= cd_cnt_ff - CNT_BITS'(1);
            cd_rem_ff <= cd_qbit ? (cd_trial[PART_BITS-1:0] - parts_eff)
                                 : cd_trial[PART_BITS-1:0];
            cd_quo_ff <= {cd_quo_ff[POSITION_BITS-2:0], cd_qbit};
         end
         default: ;
      endcase
   end

   // stall chain: a stage takes a word when it is empty or its word moves on
   always_comb begin
      out_rdy = ~rsp_valid_ff | rsp_ready;
      dv_rdy[PART_BITS] = ~dv_valid_ff[PART_BITS] | out_rdy;
      for (int i = PART_BITS - 1; i >= 0; i--) begin
         dv_rdy[i] = ~dv_valid_ff[i] | dv_rdy[i+1];
      end
      s1_rdy = ~s1_valid_ff | dv_rdy[0];
   end

   assign req_ready = s1_rdy & (seq_ff == SQ_IDLE) & ~csr_wr;
   assign accept    = req_valid & req_ready;

   // stage 1: global position and range checks
   assign pos_sum = SUM_BITS'(start_ff) + SUM_BITS'(req_element_offset);

   always_comb begin
      if (SUM_BITS'(req_element_offset) >= SUM_BITS'(local_count_ff)) begin
         entry_status = ST_OFFSET;
      end else if (pos_sum >= SUM_BITS'(total_ff)) begin
         // also covers a sum that leaves the position width
         entry_status = ST_RANGE;
      end else begin
         entry_status = ST_OK;
      end
   end

   // stage 2: pick the block size and rebase past the larger blocks
   assign s1_pos_low = s1_pos_ff[POSITION_BITS-1:0];
   assign pos_lt     = s1_pos_low < thresh_ff;
   assign dividend   = pos_lt ? s1_pos_low : (s1_pos_low - thresh_ff);

   always_comb begin
      load_item         = '0;
      load_item.status  = s1_status_ff;
      load_item.rem     = POSITION_BITS'(dividend >> PART_BITS);
      load_item.dvd_lo  = dividend[PART_BITS-1:0];
      load_item.divisor = pos_lt ? div_hi_ff : div_lo_ff;
      load_item.addend  = pos_lt ? '0 : extra_ff;
      load_item.quo     = '0;
   end

   assign last_item = dv_ff[PART_BITS];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= PART_BITS; i++) begin
            dv_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (s1_rdy) s1_valid_ff <= accept;
         if (dv_rdy[0]) dv_valid_ff[0] <= s1_valid_ff;
         for (int i = 1; i <= PART_BITS; i++) begin
            if (dv_rdy[i]) dv_valid_ff[i] <= dv_valid_ff[i-1];
         end
         if (out_rdy) rsp_valid_ff <= dv_valid_ff[PART_BITS];
      end
   end

   // payload: entry, divide steps, owner add
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_pos_ff    <= pos_sum;
         s1_status_ff <= entry_status;
      end
      if (dv_rdy[0]) dv_ff[0] <= load_item;
      for (int i = 1; i <= PART_BITS; i++) begin
         if (dv_rdy[i]) dv_ff[i] <= div_step(dv_ff[i-1]);
      end
      if (out_rdy) begin
         rsp_status_ff <= last_item.status;
         rsp_owner_ff  <= (last_item.status == ST_OK) ? (last_item.quo + last_item.addend)
                                                      : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_owner_part = rsp_owner_ff;
   assign rsp_status     = rsp_status_ff;

   // pipeline occupancy for checks
   always_comb begin
      pipe_busy = s1_valid_ff | rsp_valid_ff;
      for (int i = 0; i <= PART_BITS; i++) begin
         pipe_busy = pipe_busy | dv_valid_ff[i];
      end
   end

   // a faulted word never carries an owner
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_owner_part == '0))
      else $error("owner nonzero on faulted word");

   // only defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_OFFSET) ||
                    (rsp_status == ST_RANGE))
      else $error("undefined status code");

   // derived values never change under words in flight
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SQ_IDLE) |-> !pipe_busy)
      else $error("setup division with words in flight");

   // nothing is taken while setup runs
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SQ_IDLE) |-> !req_ready)
      else $error("input taken during setup");

endmodule

@@ tb/sv/bpd_owner_checker.sv @@
`timescale 1ns / 1ps
// owner-part checker for block_partition_destination: snoops the csr port and
// both word channels, predicts each result and compares. depends on bpd_pkg.
module bpd_owner_checker
   import bpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [OFFSET_BITS-1:0] req_element_offset,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [PART_BITS-1:0]   rsp_owner_part,
   input  logic [STATUS_BITS-1:0] rsp_status,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_BITS-1:0]   paddr,
   input  logic [DATA_BITS-1:0]   pwdata,
   input  logic                   pready,
   output int                     fail_count,
   output int                     pending,
   output int                     owned_count,
   output int                     offset_fault_count,
   output int                     range_fault_count
);

   typedef struct packed {
      logic [PART_BITS-1:0] owner;
      status_type           status;
   } owner_word_type;

   // shadow copy of the csr values
   logic [PART_BITS-1:0]     parts_cfg;
   logic [POSITION_BITS-1:0] total_cfg;
   logic [POSITION_BITS-1:0] start_cfg;
   logic [POSITION_BITS-1:0] local_cfg;

   owner_word_type owner_q[$];

   // owner of start + offset under the balanced block split
   function automatic owner_word_type owning_part_of(input logic [OFFSET_BITS-1:0] offset);
      logic [63:0] parts;
      logic [63:0] total;
      logic [63:0] pos;
      logic [63:0] base;
      logic [63:0] extra;
      logic [63:0] q;
      logic [63:0] owner;
      owner_word_type w;
      parts   = (parts_cfg == '0) ? 64'd1 : 64'(parts_cfg);
      total   = 64'(total_cfg);
      pos     = 64'(start_cfg) + 64'(offset);
      owner   = '0;
      w.owner = '0;
      if (64'(offset) >= 64'(local_cfg)) begin
         w.status = ST_OFFSET;
      end else if (pos > 64'({POSITION_BITS{1'b1}}) || pos >= total) begin
         // carry out of the position width counts as past the total
         w.status = ST_RANGE;
      end else begin
         w.status = ST_OK;
         if (total < parts) begin
            owner = pos;
         end else begin
            base  = total / parts;
            extra = total % parts;
            if (extra == 0) begin
               owner = pos / base;
            end else begin
               // the first extra parts hold base+1 elements each
               q = pos / (base + 1);
               if (q < extra)
                  owner = q;
               else
                  owner = extra + (pos - extra * (base + 1)) / base;
            end
         end
         w.owner = owner[PART_BITS-1:0];
      end
      return w;
   endfunction

   always @(posedge clock) begin
      reg_index_type  idx;
      owner_word_type exp_w;
      if (reset) begin
         parts_cfg          = PART_BITS'(1);
         total_cfg          = '0;
         start_cfg          = '0;
         local_cfg          = '0;
         owner_q.delete();
         fail_count         <= 0;
         owned_count        <= 0;
         offset_fault_count <= 0;
         range_fault_count  <= 0;
      end else begin
         // csr write snoop
         if (psel && penable && pwrite && pready) begin
            idx = paddr[ADDR_BITS-1:STRIDE_BITS];
            case (idx)
               REG_NUM_PARTS:      parts_cfg = pwdata[PART_BITS-1:0];
               REG_TOTAL_ELEMENTS: total_cfg = pwdata[POSITION_BITS-1:0];
               REG_START_POSITION: start_cfg = pwdata[POSITION_BITS-1:0];
               REG_LOCAL_COUNT:    local_cfg = pwdata[POSITION_BITS-1:0];
               default: ;
            endcase
         end
         // result word against oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (owner_q.size() == 0) begin
               $display("%0t: unexpected result word owner=%0d status=%0d",
                        $time, rsp_owner_part, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = owner_q.pop_front();
               if (rsp_owner_part !== exp_w.owner || rsp_status !== exp_w.status) begin
                  $display({"%0t: mismatch expected owner=%0d status=%0d, ",
                            "actual owner=%0d status=%0d"},
                           $time, exp_w.owner, exp_w.status, rsp_owner_part, rsp_status);
                  fail_count <= fail_count + 1;
               end
               case (exp_w.status)
                  ST_OK:     owned_count        <= owned_count + 1;
                  ST_OFFSET: offset_fault_count <= offset_fault_count + 1;
                  default:   range_fault_count  <= range_fault_count + 1;
               endcase
            end
         end
         // input word accepted
         if (req_valid && req_ready)
            owner_q.push_back(owning_part_of(req_element_offset));
      end
      pending <= owner_q.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// testbench top for block_partition_destination: clock, reset, csr setup and
// offset stimulus with random idling; checking lives in bpd_owner_checker.
module tb
   import bpd_pkg::*;
();

   localparam int RANDOM_WORDS = 1500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OFFSET_BITS-1:0] req_element_offset = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PART_BITS-1:0]   rsp_owner_part;
   logic [STATUS_BITS-1:0] rsp_status;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [ADDR_BITS-1:0]   paddr = '0;
   logic [DATA_BITS-1:0]   pwdata = '0;
   logic [DATA_BITS-1:0]   prdata;
   logic                   pready;

   int fail_count;
   int pending;
   int owned_count;
   int offset_fault_count;
   int range_fault_count;
   int cycles = 0;
   int settings = 0;
   int words_sent = 0;

   // set by the stimulus to ask the result side for one long hold-off
   logic hold_req = 1'b0;

   // current csr values, used to aim offsets
   logic [31:0] cur_total;
   logic [31:0] cur_start;
   logic [31:0] cur_local;

   // offsets around the part boundaries of seven parts over 100 elements
   logic [31:0] off_list_a [8] = '{32'd0, 32'd14, 32'd15, 32'd29, 32'd30, 32'd99,
                                   32'd100, 32'hFFFF_FFFF};

   block_partition_destination DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_element_offset(req_element_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_owner_part(rsp_owner_part), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bpd_owner_checker owner_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_element_offset(req_element_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_owner_part(rsp_owner_part), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending), .owned_count(owned_count),
      .offset_fault_count(offset_fault_count), .range_fault_count(range_fault_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("block_partition_destination test failed");
         $finish;
      end
   end

   // write all four registers back to back, psel held across the writes
   task automatic configure(input logic [31:0] parts, input logic [31:0] total,
                            input logic [31:0] start, input logic [31:0] count);
      logic [31:0]   vals [4];
      reg_index_type idx [4];
      vals = '{parts, total, start, count};
      idx  = '{REG_NUM_PARTS, REG_TOTAL_ELEMENTS, REG_START_POSITION, REG_LOCAL_COUNT};
      for (int i = 0; i < 4; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {idx[i], {STRIDE_BITS{1'b0}}};
         pwdata  <= DATA_BITS'(vals[i]);
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_total = total;
      cur_start = start;
      cur_local = count;
      settings++;
   endtask

   // offer one word after a random gap, return on the accepting edge
   task automatic send_word(input logic [31:0] offset, input int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_element_offset <= offset;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
   endtask

   // drop valid and let every outstanding result drain
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // result side: random stalls, one long hold-off to back the pipeline up
   initial begin
      int   stall;
      int   max_stall;
      int   taken;
      logic held;
      taken     = 0;
      max_stall = 5;
      held      = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 64 == 0)
            max_stall = ($urandom_range(0, 2) == 0) ? 0 : 5;
         if (hold_req && !held) begin
            held  = 1'b1;
            stall = LONG_HOLD;
         end else begin
            stall = $urandom_range(0, max_stall);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // stimulus
   initial begin
      logic [31:0] p;
      logic [31:0] t;
      logic [31:0] s;
      logic [31:0] l;
      logic [31:0] off;
      int          n;
      int          max_gap;
      int          random_words;
      random_words = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: empty local run
      send_word(32'd0, 2);
      drain();

      // seven parts over 100 elements, first two hold one extra
      configure(32'd7, 32'd100, 32'd0, 32'hFFFF_FFFF);
      foreach (off_list_a[i]) send_word(off_list_a[i], 3);
      drain();

      // zero part count near the top of the position range, overflow and both faults
      configure(32'd0, 32'd5, 32'hFFFF_FFF0, 32'h20);
      send_word(32'h0, 0);
      send_word(32'h10, 0);
      send_word(32'h20, 0);
      send_word(32'h1F, 0);
      drain();

      // zero part count acting as one part
      configure(32'd0, 32'd50, 32'd10, 32'd100);
      send_word(32'd0, 1);
      send_word(32'd39, 1);
      send_word(32'd40, 1);
      drain();

      // total below the part count: owner is the position itself
      configure(32'd65535, 32'd10, 32'd3, 32'd10);
      send_word(32'd0, 0);
      send_word(32'd6, 0);
      send_word(32'd7, 0);
      drain();

      // widest parts and total
      configure(32'd65535, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFE, 0);
      send_word(32'hFFFF_FFFF, 0);
      send_word(32'h1234_5678, 0);
      drain();

      // result side holds off while a gapless burst fills the pipeline
      configure(32'd7, 32'd100, 32'd0, 32'd100);
      hold_req = 1'b1;
      for (int i = 0; i < 60; i++) send_word(32'(i), 0);
      drain();

      // random settings, each followed by a burst of offsets
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 5))
            0:       p = 32'd0;
            1:       p = 32'd1;
            2:       p = 32'd65535;
            3, 4:    p = $urandom_range(2, 16);
            default: p = $urandom_range(2, 65535);
         endcase
         case ($urandom_range(0, 5))
            0:       t = 32'd0;
            1:       t = 32'hFFFF_FFFF;
            2:       t = $urandom_range(0, (p == 0) ? 1 : p);
            3:       t = ((p == 0) ? 32'd1 : p) * $urandom_range(1, 200);
            4:       t = $urandom_range(0, 5000);
            default: t = $urandom;
         endcase
         case ($urandom_range(0, 5))
            0:       s = 32'd0;
            1:       s = 32'hFFFF_FFFF - $urandom_range(0, 100);
            2:       s = $urandom;
            default: s = (t == 0) ? 32'd0 : $urandom_range(0, t - 1);
         endcase
         case ($urandom_range(0, 5))
            0:       l = 32'd0;
            1:       l = 32'hFFFF_FFFF;
            2:       l = t - s + $urandom_range(0, 3);
            default: l = $urandom_range(1, 3000);
         endcase
         configure(p, t, s, l);
         n       = $urandom_range(20, 120);
         max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               6:       off = $urandom;
               7:       off = cur_local + $urandom_range(0, 2) - 1;
               8, 9:    off = cur_total - cur_start + $urandom_range(0, 2) - 1;
               default: off = (cur_local == 0) ? $urandom : $urandom_range(0, cur_local - 1);
            endcase
            send_word(off, max_gap);
         end
         random_words += n;
         drain();
      end

      // let any stray word show up
      repeat (40) @(posedge clock);
      $display("sent %0d words over %0d register settings", words_sent, settings);
      $display("results: %0d owned, %0d past the local run, %0d past the total",
               owned_count, offset_fault_count, range_fault_count);
      if (fail_count == 0 && pending == 0) begin
         $display("block_partition_destination test passed");
      end else begin
         $display("%0d failures, %0d results never arrived", fail_count, pending);
         $display("block_partition_destination test failed");
      end
      $finish;
   end

endmodule
